>>> rtl/tte_pkg.sv
package tte_pkg;

   localparam int HISTORY_DEPTH = 10;
   localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
   localparam int SUM_W         = 16 + $clog2(HISTORY_DEPTH);
   localparam int DIV_W         = 32;
   localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 8;

   // floor(sum / HISTORY_DEPTH) as (sum * AVG_RECIP) >> AVG_SHIFT, exact over the sum range
   localparam int AVG_SHIFT  = 27;
   localparam int AVG_PROD_W = SUM_W + AVG_SHIFT;
   localparam logic [AVG_SHIFT-1:0] AVG_RECIP =
      AVG_SHIFT'((2 ** AVG_SHIFT + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

   localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [15:0] SAT16         = 16'hFFFF;
   localparam logic [2:0]  CONF_MAX      = 3'd4;

   localparam logic [HIST_IDX_W-1:0] HIST_IDX_FIRST = HIST_IDX_W'(1 % HISTORY_DEPTH);
   localparam logic [HIST_IDX_W-1:0] HIST_IDX_LAST  = HIST_IDX_W'(HISTORY_DEPTH - 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_MODE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_ENABLE  = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      CMD_TAP        = 2'd0,
      CMD_RESET      = 2'd1,
      CMD_LAMP_RESET = 2'd2,
      CMD_TICK       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      DIV_TEMPO    = 2'd0,
      DIV_INTERVAL = 2'd1
   } div_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        first_tap;
      logic        beat_step;
      logic        mul_load;
      logic        div_start;
      div_sel_type div_sel;
      logic        tempo_cap;
      logic        hist_update;
      logic        sum_step;
      logic        avg_cap;
      logic        conf_cap;
      logic        interval_cap;
      logic        state_clear;
      logic        lamp_clear;
      logic        tick;
      logic        out_load;
   } dp_ctrl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    running;
      logic    first_beat;
      logic    div_done;
      logic    sum_last;
   } dp_status_type;

   // 4 at zero distance, one less per step, 0 beyond three
   function automatic logic [2:0] conf_of(input logic [15:0] delta);
      logic [2:0] level;
      if (delta <= 16'd3) begin
         level = CONF_MAX - delta[2:0];
      end else begin
         level = 3'd0;
      end
      return level;
   endfunction

endpackage

>>> rtl/tte_div.sv
module tte_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tte_pkg::DIV_W-1:0] dividend,
   input  logic [tte_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [tte_pkg::DIV_W-1:0] quotient
);
   import tte_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_W:0]       trial;
   logic                 fits;

   // restoring division, one quotient bit per cycle; quotient shifts into dvd
   always_comb begin
      trial  = {rem_ff, dvd_ff[DIV_W-1]};
      fits   = trial >= {1'b0, dvs_ff};
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = DIV_CNT_W'(DIV_W);
         rem_in = '0;
         dvd_in = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = cnt_ff == DIV_CNT_W'(1);
         if (fits) begin
            rem_in = DIV_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         dvd_in = {dvd_ff[DIV_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

>>> rtl/tte_dp.sv
module tte_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  tte_pkg::dp_ctrl_type            ctrl,
   output tte_pkg::dp_status_type          status,
   input  logic [1:0]                      req_cmd,
   input  logic [31:0]                     req_time_ms,
   input  logic                            csr_we,
   input  logic [tte_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tte_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic [15:0]                     rsp_tempo_bpm,
   output logic [15:0]                     rsp_beat_total,
   output logic [2:0]                      rsp_confidence,
   output logic [15:0]                     rsp_interval_ms,
   output logic [2:0]                      rsp_lamp,
   output logic                            rsp_buzz,
   output logic                            rsp_running
);
   import tte_pkg::*;

   // configuration
   logic [1:0] display_mode_ff, display_mode_in;
   logic       tone_enable_ff, tone_enable_in;

   // tracking state
   logic                  running_ff, running_in;
   logic [31:0]           start_ff, start_in;
   logic [15:0]           beat_ff, beat_in;
   logic [15:0]           hist_ff [HISTORY_DEPTH];
   logic [15:0]           hist_in [HISTORY_DEPTH];
   logic [HIST_IDX_W-1:0] hidx_ff, hidx_in;
   logic [1:0]            lamp_pos_ff, lamp_pos_in;
   logic [15:0]           tempo_ff, tempo_in;
   logic [2:0]            conf_ff, conf_in;
   logic [15:0]           interval_ff, interval_in;
   logic [2:0]            lamp_ff, lamp_in;
   logic                  buzz_ff, buzz_in;

   // working registers
   cmd_type               cmd_ff, cmd_in;
   logic [31:0]           time_ff, time_in;
   logic [31:0]           elapsed_ff, elapsed_in;
   logic [31:0]           prod_ff, prod_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [HIST_IDX_W-1:0] sidx_ff, sidx_in;
   logic [15:0]           avg_ff, avg_in;

   // divider
   logic             div_done;
   logic [DIV_W-1:0] div_q;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;

   // tick, average and confidence helpers
   logic [2:0]            lamp_n;
   logic [2:0]            lamp_p;
   logic [2:0]            lamp_next;
   logic [AVG_PROD_W-1:0] avg_prod;
   logic [15:0]           delta;

   always_comb begin
      case (ctrl.div_sel)
         DIV_TEMPO: begin
            div_dividend = prod_ff;
            div_divisor  = elapsed_ff;
         end
         DIV_INTERVAL: begin
            div_dividend = DIV_W'(MS_PER_MINUTE);
            div_divisor  = DIV_W'(tempo_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   tte_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      lamp_n    = {1'b0, display_mode_ff} + 3'd1;
      lamp_p    = ({1'b0, lamp_pos_ff} >= lamp_n) ? 3'd0 : {1'b0, lamp_pos_ff};
      lamp_next = lamp_p + 3'd1;
      avg_prod  = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_RECIP);
      delta     = (avg_ff > tempo_ff) ? avg_ff - tempo_ff : tempo_ff - avg_ff;
   end

   always_comb begin
      display_mode_in = display_mode_ff;
      tone_enable_in  = tone_enable_ff;
      running_in      = running_ff;
      start_in        = start_ff;
      beat_in         = beat_ff;
      hist_in         = hist_ff;
      hidx_in         = hidx_ff;
      lamp_pos_in     = lamp_pos_ff;
      tempo_in        = tempo_ff;
      conf_in         = conf_ff;
      interval_in     = interval_ff;
      lamp_in         = lamp_ff;
      buzz_in         = buzz_ff;
      cmd_in          = cmd_ff;
      time_in         = time_ff;
      elapsed_in      = elapsed_ff;
      prod_in         = prod_ff;
      sum_in          = sum_ff;
      sidx_in         = sidx_ff;
      avg_in          = avg_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_DISPLAY_MODE: display_mode_in = csr_wdata[1:0];
            CSR_TONE_ENABLE:  tone_enable_in  = csr_wdata[0];
            default: ;
         endcase
      end

      if (ctrl.load_req) begin
         cmd_in  = cmd_type'(req_cmd);
         time_in = req_time_ms;
         lamp_in = 3'd0;
         buzz_in = 1'b0;
      end

      if (ctrl.first_tap) begin
         running_in = 1'b1;
         start_in   = time_ff;
      end

      if (ctrl.beat_step) begin
         if (beat_ff != SAT16) begin
            beat_in = beat_ff + 16'd1;
         end
         elapsed_in = time_ff - start_ff;
      end

      if (ctrl.mul_load) begin
         prod_in = 32'(beat_ff) * 32'(MS_PER_MINUTE);
      end

      if (ctrl.tempo_cap) begin
         if (elapsed_ff == '0 || div_q[DIV_W-1:16] != '0) begin
            tempo_in = SAT16;
         end else begin
            tempo_in = div_q[15:0];
         end
      end

      if (ctrl.hist_update) begin
         if (beat_ff == 16'd1) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               hist_in[i] = tempo_ff;
            end
            hidx_in = HIST_IDX_FIRST;
            conf_in = CONF_MAX;
         end else begin
            hist_in[hidx_ff] = tempo_ff;
         end
         sum_in  = '0;
         sidx_in = '0;
      end

      if (ctrl.sum_step) begin
         sum_in  = sum_ff + SUM_W'(hist_ff[sidx_ff]);
         sidx_in = sidx_ff + 1'b1;
      end

      if (ctrl.avg_cap) begin
         avg_in = 16'(avg_prod >> AVG_SHIFT);
      end

      if (ctrl.conf_cap) begin
         conf_in = conf_of(delta);
         hidx_in = (hidx_ff == HIST_IDX_LAST) ? '0 : hidx_ff + 1'b1;
      end

      if (ctrl.interval_cap) begin
         interval_in = (tempo_ff == '0) ? 16'd0 : div_q[15:0];
      end

      if (ctrl.state_clear) begin
         running_in  = 1'b0;
         start_in    = '0;
         beat_in     = '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_in[i] = '0;
         end
         hidx_in     = '0;
         lamp_pos_in = '0;
         tempo_in    = '0;
         conf_in     = '0;
         interval_in = '0;
      end

      if (ctrl.lamp_clear) begin
         lamp_pos_in = '0;
      end

      if (ctrl.tick) begin
         buzz_in = tone_enable_ff;
         if (display_mode_ff != 2'd0) begin
            lamp_in     = lamp_next;
            lamp_pos_in = (lamp_next == lamp_n) ? 2'd0 : lamp_next[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_mode_ff <= '0;
         tone_enable_ff  <= 1'b0;
         running_ff      <= 1'b0;
         start_ff        <= '0;
         beat_ff         <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         hidx_ff         <= '0;
         lamp_pos_ff     <= '0;
         tempo_ff        <= '0;
         conf_ff         <= '0;
         interval_ff     <= '0;
         lamp_ff         <= '0;
         buzz_ff         <= 1'b0;
      end else begin
         display_mode_ff <= display_mode_in;
         tone_enable_ff  <= tone_enable_in;
         running_ff      <= running_in;
         start_ff        <= start_in;
         beat_ff         <= beat_in;
         hist_ff         <= hist_in;
         hidx_ff         <= hidx_in;
         lamp_pos_ff     <= lamp_pos_in;
         tempo_ff        <= tempo_in;
         conf_ff         <= conf_in;
         interval_ff     <= interval_in;
         lamp_ff         <= lamp_in;
         buzz_ff         <= buzz_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      time_ff    <= time_in;
      elapsed_ff <= elapsed_in;
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      sidx_ff    <= sidx_in;
      avg_ff     <= avg_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_tempo_bpm   <= tempo_ff;
         rsp_beat_total  <= beat_ff;
         rsp_confidence  <= conf_ff;
         rsp_interval_ms <= interval_ff;
         rsp_lamp        <= lamp_ff;
         rsp_buzz        <= buzz_ff;
         rsp_running     <= running_ff;
      end
   end

   assign status.cmd        = cmd_ff;
   assign status.running    = running_ff;
   assign status.first_beat = beat_ff == 16'd1;
   assign status.div_done   = div_done;
   assign status.sum_last   = sidx_ff == HIST_IDX_LAST;

endmodule

>>> rtl/tte_ctrl.sv
module tte_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tte_pkg::dp_ctrl_type   ctrl,
   input  tte_pkg::dp_status_type status
);
   import tte_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_TAP_MUL,
      S_TEMPO_DIV,
      S_TEMPO_WAIT,
      S_HIST_UPD,
      S_HIST_SUM,
      S_AVG_MUL,
      S_AVG_CONF,
      S_IVL_DIV,
      S_IVL_WAIT,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ctrl         = '0;
      ctrl.div_sel = DIV_TEMPO;
      out_free     = !rsp_valid_ff || rsp_ready;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load_req = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_RESULT;
            case (status.cmd)
               CMD_TAP: begin
                  if (status.running) begin
                     ctrl.beat_step = 1'b1;
                     state_in       = S_TAP_MUL;
                  end else begin
                     ctrl.first_tap = 1'b1;
                  end
               end
               CMD_RESET:      ctrl.state_clear = 1'b1;
               CMD_LAMP_RESET: ctrl.lamp_clear  = 1'b1;
               CMD_TICK:       ctrl.tick        = 1'b1;
               default: ;
            endcase
         end
         S_TAP_MUL: begin
            ctrl.mul_load = 1'b1;
            state_in      = S_TEMPO_DIV;
         end
         S_TEMPO_DIV: begin
            ctrl.div_start = 1'b1;
            ctrl.div_sel   = DIV_TEMPO;
            state_in       = S_TEMPO_WAIT;
         end
         S_TEMPO_WAIT: begin
            if (status.div_done) begin
               ctrl.tempo_cap = 1'b1;
               state_in       = S_HIST_UPD;
            end
         end
         S_HIST_UPD: begin
            ctrl.hist_update = 1'b1;
            // first beat fills the ring and skips the average
            state_in = status.first_beat ? S_IVL_DIV : S_HIST_SUM;
         end
         S_HIST_SUM: begin
            ctrl.sum_step = 1'b1;
            if (status.sum_last) begin
               state_in = S_AVG_MUL;
            end
         end
         S_AVG_MUL: begin
            ctrl.avg_cap = 1'b1;
            state_in     = S_AVG_CONF;
         end
         S_AVG_CONF: begin
            ctrl.conf_cap = 1'b1;
            state_in      = S_IVL_DIV;
         end
         S_IVL_DIV: begin
            ctrl.div_start = 1'b1;
            ctrl.div_sel   = DIV_INTERVAL;
            state_in       = S_IVL_WAIT;
         end
         S_IVL_WAIT: begin
            if (status.div_done) begin
               ctrl.interval_cap = 1'b1;
               state_in          = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               ctrl.out_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/tap_tempo_estimator.sv
// Sequence: a tap after the first runs dispatch, the product load, two serial divisions
// (tempo, interval), the history update, a HISTORY_DEPTH-entry history sum, the average and
// confidence captures and the result step; the first beat skips the average, and other requests
// go from dispatch to the result. Throughput: one request in flight; the next is taken the
// cycle after the response enters the output register, which waits until the last one is taken.
// Reset (synchronous): clears all tracking state, history and both control registers.
module tap_tempo_estimator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_cmd,
   input  logic [31:0]                     req_time_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [15:0]                     rsp_tempo_bpm,
   output logic [15:0]                     rsp_beat_total,
   output logic [2:0]                      rsp_confidence,
   output logic [15:0]                     rsp_interval_ms,
   output logic [2:0]                      rsp_lamp,
   output logic                            rsp_buzz,
   output logic                            rsp_running,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tte_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tte_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tte_pkg::*;

   dp_ctrl_type   ctrl;
   dp_status_type status;

   assign csr_ready = 1'b1;

   tte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl),
      .status    (status)
   );

   tte_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_time_ms     (req_time_ms),
      .csr_we          (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_tempo_bpm   (rsp_tempo_bpm),
      .rsp_beat_total  (rsp_beat_total),
      .rsp_confidence  (rsp_confidence),
      .rsp_interval_ms (rsp_interval_ms),
      .rsp_lamp        (rsp_lamp),
      .rsp_buzz        (rsp_buzz),
      .rsp_running     (rsp_running)
   );

endmodule
